>>> design/grc_pkg.sv
// shared constants, types and the arctangent table of the grid ray caster
package grc_pkg;

  localparam int GRID_SIDE       = 256;
  localparam int GRID_AW         = $clog2(GRID_SIDE);
  localparam int ANGLE_BITS      = 16;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int QUEUE_DEPTH     = 2;

  localparam int COORD_W  = 11;
  localparam int SIZE_W   = 9;
  localparam int CODE_W   = 8;
  localparam int ANGLE_W  = 16;
  localparam int REASON_W = 2;
  localparam int POS_W    = SIZE_W + 1;
  localparam int ALPHA_W  = ANGLE_BITS - 2;
  localparam int SLOPE_W  = SLOPE_FRAC_BITS + 1;
  localparam int ERR_W    = SLOPE_FRAC_BITS + 3;
  localparam int CORDIC_W = 34;
  localparam int ITER_W   = $clog2(CORDIC_STEPS);

  localparam logic [ANGLE_BITS-1:0] ANG_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] ANG_Q    = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
  localparam logic [SLOPE_W-1:0]    SLOPE_ONE = SLOPE_W'(1) << SLOPE_FRAC_BITS;

  typedef enum logic [1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_OBSTACLE   = 2'd2,
    CFG_UNKNOWN    = 2'd3
  } cfg_index_t;

  typedef enum logic [REASON_W-1:0] {
    STOP_OBSTACLE   = 2'd0,
    STOP_UNKNOWN    = 2'd1,
    STOP_WALK_EDGE  = 2'd2,
    STOP_START_EDGE = 2'd3
  } stop_reason_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EDGE  = 2'd1,
    OP_WALK  = 2'd2
  } op_kind_t;

  // one classified request as it waits between front and back
  typedef struct packed {
    op_kind_t               kind;
    logic [SIZE_W-1:0]      x;
    logic [SIZE_W-1:0]      y;
    logic [CODE_W-1:0]      value;
    logic [ALPHA_W-1:0]     alpha;
    logic                   x_major;
    logic                   major_neg;
    logic                   minor_neg;
  } op_t;

  // atan(2^-i) with a full turn as 2^32
  function automatic logic [31:0] turn_atan(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/grid_ray_cast.sv
// top level of the occupancy-grid ray caster
//
// Input channel (in_valid / in_stall): a request with in_kind 0 writes
// in_cell_value into the grid cell (in_cell_x, in_cell_y), one with
// in_kind 1 casts a ray from that cell along in_angle. Writes give no result,
// every cast gives one result on the out_ channel (out_valid / out_stall).
// A two-entry queue sits between the front end and the walker, so requests
// are taken while the walker is busy or a result waits to be taken.
// A write is stored as soon as it reaches the idle walker. A cast whose
// start is on or outside the map edge goes from the queue straight to the
// result register. Any other cast runs the slope unit (30 cordic rotations
// and a 17-step divide), then walks one grid cell per cycle while the
// result register is free; a single read port of the 64k-entry grid memory
// sets that pace. Casts are handled one after another.
// Reset clears control state and loads map size 256 by 256, obstacle code
// 100 and unknown code 255; grid contents are undefined until written.
// A stalled result holds, the walker waits and the queue fills behind it.
// Configuration (cfg_we) may only be written while the block is idle.
module grid_ray_cast (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [grc_pkg::COORD_W-1:0] in_cell_x,
  input  logic signed [grc_pkg::COORD_W-1:0] in_cell_y,
  input  logic [grc_pkg::CODE_W-1:0]         in_cell_value,
  input  logic signed [grc_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [grc_pkg::SIZE_W-1:0]         out_end_x,
  output logic [grc_pkg::SIZE_W-1:0]         out_end_y,
  output logic [grc_pkg::REASON_W-1:0]       out_stop_reason,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [grc_pkg::SIZE_W-1:0]         cfg_wdata
);

  logic [grc_pkg::SIZE_W-1:0]  map_width_r, map_height_r, w_eff, h_eff;
  logic [grc_pkg::CODE_W-1:0]  obstacle_r, unknown_r;
  logic                        push_ok, q_full, head_valid, pop;
  grc_pkg::op_t                op, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= grc_pkg::SIZE_W'(256);
      map_height_r <= grc_pkg::SIZE_W'(256);
      obstacle_r   <= grc_pkg::CODE_W'(100);
      unknown_r    <= grc_pkg::CODE_W'(255);
    end else if (cfg_we) begin
      unique case (grc_pkg::cfg_index_t'(cfg_index))
        grc_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        grc_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        grc_pkg::CFG_OBSTACLE:   obstacle_r   <= cfg_wdata[grc_pkg::CODE_W-1:0];
        grc_pkg::CFG_UNKNOWN:    unknown_r    <= cfg_wdata[grc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes beyond the store act as the full store
  assign w_eff = (map_width_r  > grc_pkg::SIZE_W'(grc_pkg::GRID_SIDE))
               ? grc_pkg::SIZE_W'(grc_pkg::GRID_SIDE) : map_width_r;
  assign h_eff = (map_height_r > grc_pkg::SIZE_W'(grc_pkg::GRID_SIDE))
               ? grc_pkg::SIZE_W'(grc_pkg::GRID_SIDE) : map_height_r;

  assign in_stall = q_full;

  grc_front u_front (
    .in_kind       (in_kind),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_value (in_cell_value),
    .in_angle      (in_angle),
    .w             (w_eff),
    .h             (h_eff),
    .push_ok       (push_ok),
    .op            (op)
  );

  grc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full && push_ok),
    .push_data  (op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  grc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .w               (w_eff),
    .h               (h_eff),
    .obstacle_code   (obstacle_r),
    .unknown_code    (unknown_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_stop_reason (out_stop_reason)
  );

  // a ray only stops on a cell value strictly inside the map
  a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stop_reason == grc_pkg::STOP_OBSTACLE ||
                  out_stop_reason == grc_pkg::STOP_UNKNOWN)
    |-> out_end_x != '0 && out_end_y != '0 && out_end_x < w_eff && out_end_y < h_eff)
    else $error("ray stopped on a cell outside the map interior");

  // a walk that runs out ends on the border
  a_walk_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_reason == grc_pkg::STOP_WALK_EDGE
    |-> out_end_x == '0 || out_end_y == '0 || out_end_x == w_eff || out_end_y == h_eff)
    else $error("edge result not on the map border");

  // the queue only pops what it holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("request queue popped while empty");

endmodule

>>> design/grc_front.sv
// request front end: decodes writes, clamps edge starts, folds the ray angle
module grc_front (
  input  logic                              in_kind,
  input  logic signed [grc_pkg::COORD_W-1:0] in_cell_x,
  input  logic signed [grc_pkg::COORD_W-1:0] in_cell_y,
  input  logic [grc_pkg::CODE_W-1:0]        in_cell_value,
  input  logic signed [grc_pkg::ANGLE_W-1:0] in_angle,
  input  logic [grc_pkg::SIZE_W-1:0]        w,
  input  logic [grc_pkg::SIZE_W-1:0]        h,
  output logic                              push_ok,
  output grc_pkg::op_t                      op
);

  localparam int AB = grc_pkg::ANGLE_BITS;
  localparam logic [AB-1:0] Q2 = grc_pkg::ANG_Q << 1;
  localparam logic [AB-1:0] Q3 = AB'(3) * grc_pkg::ANG_Q;

  logic signed [grc_pkg::COORD_W-1:0] ws, hs;
  logic                               fx, fy, in_store;
  logic [AB-1:0]                      u, ab, alpha_full;
  logic signed [AB:0]                 a, a_abs;

  assign ws = $signed({{(grc_pkg::COORD_W-grc_pkg::SIZE_W){1'b0}}, w});
  assign hs = $signed({{(grc_pkg::COORD_W-grc_pkg::SIZE_W){1'b0}}, h});

  assign fx = (in_cell_x >= ws) || (in_cell_x <= 0);
  assign fy = (in_cell_y >= hs) || (in_cell_y <= 0);
  assign in_store = (in_cell_x[grc_pkg::COORD_W-1:grc_pkg::GRID_AW] == '0) &&
                    (in_cell_y[grc_pkg::COORD_W-1:grc_pkg::GRID_AW] == '0);

  // angle taken into (-pi, pi], minus pi acts as plus pi
  assign u     = AB'($signed(in_angle));
  assign a     = (u <= grc_pkg::ANG_HALF) ? $signed({1'b0, u}) : $signed({1'b1, u});
  assign a_abs = (a < 0) ? -a : a;
  assign ab    = a_abs[AB-1:0];

  always_comb begin
    op           = '0;
    op.value     = in_cell_value;
    op.x_major   = (ab <= grc_pkg::ANG_Q) || (ab >= Q3);
    if (op.x_major) begin
      alpha_full   = (ab <= grc_pkg::ANG_Q) ? ab : grc_pkg::ANG_HALF - ab;
      op.major_neg = !(ab <= grc_pkg::ANG_Q);
      op.minor_neg = (a < 0);
    end else begin
      alpha_full   = (ab > Q2) ? ab - Q2 : Q2 - ab;
      op.major_neg = !(a > 0);
      op.minor_neg = !(ab <= Q2);
    end
    op.alpha = alpha_full[grc_pkg::ALPHA_W-1:0];
    push_ok  = 1'b1;
    if (!in_kind) begin
      op.kind = grc_pkg::OP_WRITE;
      op.x    = grc_pkg::SIZE_W'(in_cell_x[grc_pkg::GRID_AW-1:0]);
      op.y    = grc_pkg::SIZE_W'(in_cell_y[grc_pkg::GRID_AW-1:0]);
      push_ok = in_store;
    end else begin
      op.kind = (fx || fy) ? grc_pkg::OP_EDGE : grc_pkg::OP_WALK;
      if (in_cell_x > ws)      op.x = w;
      else if (in_cell_x < 0)  op.x = '0;
      else                     op.x = in_cell_x[grc_pkg::SIZE_W-1:0];
      if (in_cell_y > hs)      op.y = h;
      else if (in_cell_y < 0)  op.y = '0;
      else                     op.y = in_cell_y[grc_pkg::SIZE_W-1:0];
    end
  end

endmodule

>>> design/grc_queue.sv
// short request queue between front end and walker
module grc_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  grc_pkg::op_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output grc_pkg::op_t head
);

  localparam int D     = grc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
  localparam int CNT_W = $clog2(D + 1);

  grc_pkg::op_t      slot_r [D];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full       = (count_r == CNT_W'(D));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> design/grc_slope.sv
// slope unit: iterative cordic for tan, then a restoring divide to fixed point
module grc_slope (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grc_pkg::ALPHA_W-1:0]   alpha,
  output logic                          done,
  output logic [grc_pkg::SLOPE_W-1:0]   slope
);

  localparam int CW = grc_pkg::CORDIC_W;
  localparam int SW = grc_pkg::SLOPE_W;
  localparam int NW = CW + grc_pkg::SLOPE_FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_NORM = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } slope_st_t;

  slope_st_t                   st_r;
  logic signed [CW-1:0]        x_r, y_r, z_r;
  logic [grc_pkg::ITER_W-1:0]  i_r;
  logic [CW-1:0]               rem_r;
  logic [SW-1:0]               qb_r, slope_r;

  logic signed [CW-1:0]        dx, dy, at;
  logic [NW-1:0]               num;
  logic [CW:0]                 rem_sh;
  logic                        qbit;
  logic [SW-1:0]               q_new;

  function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                     input logic [grc_pkg::ITER_W-1:0] s);
    logic signed [CW-1:0] r;
    r = (v < 0) ? -((-v) >>> s) : (v >>> s);
    return r;
  endfunction

  assign dx  = shr_trunc(y_r, i_r);
  assign dy  = shr_trunc(x_r, i_r);
  assign at  = $signed(CW'(grc_pkg::turn_atan(i_r)));
  assign num = (NW'(unsigned'(y_r)) << grc_pkg::SLOPE_FRAC_BITS) + NW'(unsigned'(x_r) >> 1);
  assign rem_sh = {rem_r, qb_r[SW-1]};
  assign qbit   = (rem_sh >= {1'b0, x_r});
  assign q_new  = {qb_r[SW-2:0], qbit};

  assign done  = (st_r == S_DONE);
  assign slope = slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      i_r  <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (start) begin
          i_r <= '0;
          x_r <= CW'(1) <<< 30;
          y_r <= '0;
          z_r <= $signed(CW'(alpha) << (32 - grc_pkg::ANGLE_BITS));
          if (alpha == '0) begin
            slope_r <= '0;
            st_r    <= S_DONE;
          end else if (grc_pkg::ANGLE_BITS'(alpha) >= grc_pkg::ANG_Q) begin
            slope_r <= grc_pkg::SLOPE_ONE;
            st_r    <= S_DONE;
          end else begin
            st_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == grc_pkg::ITER_W'(grc_pkg::CORDIC_STEPS - 1)) st_r <= S_NORM;
        end
        S_NORM: begin
          i_r <= '0;
          if (y_r <= 0 || x_r <= 0) begin
            slope_r <= '0;
            st_r    <= S_DONE;
          end else begin
            rem_r <= CW'(num >> SW);
            qb_r  <= num[SW-1:0];
            st_r  <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= qbit ? CW'(rem_sh - {1'b0, x_r}) : CW'(rem_sh);
          qb_r  <= q_new;
          i_r   <= i_r + 1'b1;
          if (i_r == grc_pkg::ITER_W'(SW - 1)) begin
            slope_r <= (q_new > grc_pkg::SLOPE_ONE) ? grc_pkg::SLOPE_ONE : q_new;
            st_r    <= S_DONE;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/grc_back.sv
// back end: grid store, ray walker and result register
module grc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  grc_pkg::op_t                    head,
  output logic                            pop,
  input  logic [grc_pkg::SIZE_W-1:0]      w,
  input  logic [grc_pkg::SIZE_W-1:0]      h,
  input  logic [grc_pkg::CODE_W-1:0]      obstacle_code,
  input  logic [grc_pkg::CODE_W-1:0]      unknown_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [grc_pkg::SIZE_W-1:0]      out_end_x,
  output logic [grc_pkg::SIZE_W-1:0]      out_end_y,
  output logic [grc_pkg::REASON_W-1:0]    out_stop_reason
);

  localparam int PW = grc_pkg::POS_W;
  localparam int EW = grc_pkg::ERR_W;
  localparam int AW = grc_pkg::GRID_AW;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SLOPE = 3'b010,
    B_WALK  = 3'b100
  } back_st_t;

  back_st_t                      st_r, st_nxt;
  logic [grc_pkg::CODE_W-1:0]    grid_mem [grc_pkg::GRID_SIDE * grc_pkg::GRID_SIDE];
  logic [grc_pkg::CODE_W-1:0]    rd_data_r;
  logic signed [PW-1:0]          cx_r, cy_r, nx, ny, ws, hs;
  logic signed [EW-1:0]          e_r, e1, e2;
  logic [grc_pkg::SLOPE_W-1:0]   k_r, slope;
  logic                          x_major_r, major_neg_r, minor_neg_r, pend_r;
  logic                          slope_start, slope_done;
  logic                          out_free, mstep, at_edge, hit, step;
  logic                          mem_we, out_load;
  logic [grc_pkg::SIZE_W-1:0]    ld_x, ld_y;
  grc_pkg::stop_reason_t         ld_reason;
  logic                          out_valid_r;
  logic [grc_pkg::SIZE_W-1:0]    out_x_r, out_y_r;
  grc_pkg::stop_reason_t         out_reason_r;

  grc_slope u_slope (
    .clk   (clk),
    .rst_n (rst_n),
    .start (slope_start),
    .alpha (head.alpha),
    .done  (slope_done),
    .slope (slope)
  );

  assign ws = $signed({1'b0, w});
  assign hs = $signed({1'b0, h});
  assign out_free = !out_valid_r || !out_stall;

  // one cell per cycle while the result register is free: check the cell read at the last step while stepping on
  always_comb begin
    e1    = e_r + $signed(EW'(k_r));
    mstep = (e1 >= 0);
    e2    = mstep ? e1 - $signed(EW'(grc_pkg::SLOPE_ONE)) : e1;
    nx    = cx_r;
    ny    = cy_r;
    if (x_major_r) begin
      nx = major_neg_r ? cx_r - 2'sd1 : cx_r + 2'sd1;
      if (mstep) ny = minor_neg_r ? cy_r - 2'sd1 : cy_r + 2'sd1;
    end else begin
      ny = major_neg_r ? cy_r - 2'sd1 : cy_r + 2'sd1;
      if (mstep) nx = minor_neg_r ? cx_r - 2'sd1 : cx_r + 2'sd1;
    end
    at_edge = (nx >= ws) || (nx <= 0) || (ny >= hs) || (ny <= 0);
    hit     = pend_r && ((rd_data_r == obstacle_code) || (rd_data_r == unknown_code));
  end

  always_comb begin
    st_nxt      = st_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    slope_start = 1'b0;
    step        = 1'b0;
    ld_x        = head.x;
    ld_y        = head.y;
    ld_reason   = grc_pkg::STOP_START_EDGE;
    unique case (st_r)
      B_IDLE: if (head_valid) begin
        unique case (head.kind)
          grc_pkg::OP_WRITE: begin
            mem_we = 1'b1;
            pop    = 1'b1;
          end
          grc_pkg::OP_EDGE: if (out_free) begin
            out_load = 1'b1;
            pop      = 1'b1;
          end
          grc_pkg::OP_WALK: begin
            pop         = 1'b1;
            slope_start = 1'b1;
            st_nxt      = B_SLOPE;
          end
          default: pop = 1'b1;
        endcase
      end
      B_SLOPE: if (slope_done) st_nxt = B_WALK;
      B_WALK: if (out_free) begin
        priority if (hit) begin
          out_load  = 1'b1;
          ld_x      = cx_r[grc_pkg::SIZE_W-1:0];
          ld_y      = cy_r[grc_pkg::SIZE_W-1:0];
          ld_reason = (rd_data_r == obstacle_code) ? grc_pkg::STOP_OBSTACLE
                                                   : grc_pkg::STOP_UNKNOWN;
          st_nxt    = B_IDLE;
        end else if (at_edge) begin
          out_load  = 1'b1;
          ld_x      = nx[grc_pkg::SIZE_W-1:0];
          ld_y      = ny[grc_pkg::SIZE_W-1:0];
          ld_reason = grc_pkg::STOP_WALK_EDGE;
          st_nxt    = B_IDLE;
        end else begin
          step = 1'b1;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[{head.y[AW-1:0], head.x[AW-1:0]}] <= head.value;
  end

  always_ff @(posedge clk) begin
    if (step) rd_data_r <= grid_mem[{ny[AW-1:0], nx[AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (slope_start) begin
      cx_r        <= $signed({1'b0, head.x});
      cy_r        <= $signed({1'b0, head.y});
      x_major_r   <= head.x_major;
      major_neg_r <= head.major_neg;
      minor_neg_r <= head.minor_neg;
    end
    if (st_r == B_SLOPE && slope_done) begin
      k_r <= slope;
      e_r <= -$signed(EW'(grc_pkg::SLOPE_ONE >> 1));
    end
    if (step) begin
      cx_r <= nx;
      cy_r <= ny;
      e_r  <= e2;
    end
    if (out_load) begin
      out_x_r      <= ld_x;
      out_y_r      <= ld_y;
      out_reason_r <= ld_reason;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (slope_start)  pend_r <= 1'b0;
      else if (step)    pend_r <= 1'b1;
      if (out_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_end_x       = out_x_r;
  assign out_end_y       = out_y_r;
  assign out_stop_reason = out_reason_r;

endmodule
